@@ rtl/core/nt_pkg.sv @@
// Shared types and codes for the node table with oldest-entry eviction.
`timescale 1ns / 1ps

package nt_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      OP_HEARD = 2'd0,
      OP_EVENT = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Register word indexes on the CSR port (byte address 4*index)
   localparam logic REG_UNASSIGNED = 1'b0;
   localparam logic REG_BROADCAST  = 1'b1;

   localparam int ADDR_W  = 16;
   localparam int TIME_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 4;
   localparam int FILL_W  = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // One table slot
   typedef struct packed {
      logic [ADDR_W-1:0]        addr;
      logic [TIME_W-1:0]        last_ms;
      logic signed [BYTE_W-1:0] rssi;
      logic [BYTE_W-1:0]        snr;
      logic [BYTE_W-1:0]        hops;
      logic [TIME_W-1:0]        frames;
      logic [BYTE_W-1:0]        evt_code;
      logic [BYTE_W-1:0]        event_severity;
      logic [TIME_W-1:0]        event_epoch;
   } entry_type;

   // Sequencer controls for the scan unit
   typedef struct packed {
      logic start;     // clear match and oldest tracking
      logic sample;    // table read data is valid this cycle
      logic in_range;  // sampled slot lies below the fill count
   } scan_ctl_type;

endpackage

@@ rtl/core/nt_table.sv @@
// Slot storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module nt_table #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic [IDX_W-1:0]   rd_addr,
   output nt_pkg::entry_type  rd_data,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  nt_pkg::entry_type  wr_data
);

   nt_pkg::entry_type mem [DEPTH];
   nt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/nt_scan.sv @@
// Shared compare unit: address match and oldest last-heard pick, one slot a cycle.
`timescale 1ns / 1ps

module nt_scan #(
   parameter int IDX_W = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nt_pkg::scan_ctl_type         ctl,
   input  logic [IDX_W-1:0]             sample_idx,
   input  logic [nt_pkg::ADDR_W-1:0]    sample_addr,
   input  logic [nt_pkg::TIME_W-1:0]    sample_last_ms,
   input  logic [nt_pkg::ADDR_W-1:0]    key_addr,
   output logic                         found,
   output logic [IDX_W-1:0]             match_idx,
   output logic [IDX_W-1:0]             oldest_idx
);

   logic                      found_ff, found_in;
   logic                      first_ff, first_in;
   logic [IDX_W-1:0]          match_ff, match_in;
   logic [IDX_W-1:0]          oldest_ff, oldest_in;
   logic [nt_pkg::TIME_W-1:0] oldest_ms_ff, oldest_ms_in;

   always_comb begin
      found_in     = found_ff;
      first_in     = first_ff;
      match_in     = match_ff;
      oldest_in    = oldest_ff;
      oldest_ms_in = oldest_ms_ff;
      if (ctl.start) begin
         found_in = 1'b0;
         first_in = 1'b1;
      end else if (ctl.sample) begin
         // keep the first match only
         if (!found_ff && ctl.in_range && sample_addr == key_addr) begin
            found_in = 1'b1;
            match_in = sample_idx;
         end
         // strict less keeps the lowest index on ties
         if (first_ff || sample_last_ms < oldest_ms_ff) begin
            oldest_in    = sample_idx;
            oldest_ms_in = sample_last_ms;
         end
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         found_ff <= found_in;
         first_ff <= first_in;
      end
      match_ff     <= match_in;
      oldest_ff    <= oldest_in;
      oldest_ms_ff <= oldest_ms_in;
   end

   assign found      = found_ff;
   assign match_idx  = match_ff;
   assign oldest_idx = oldest_ff;

endmodule

@@ rtl/core/node_table_oldest_evict.sv @@
// Top level of the node table: CSR port, request sequencer and response register.
`timescale 1ns / 1ps

// Node table keyed by 16-bit node address, NODE_SLOTS entries. A heard request
// for an address that is not reserved, or an event request, walks the whole
// table through one compare unit over the table's single read port, one slot
// per cycle, to find the address or else pick the next free slot or, when the
// table is full, the slot heard longest ago. A found slot is read back in
// S_FETCH and S_FETCH_WAIT, as is the slot of an in-range read; ignored requests
// go straight to S_RESPOND. req_tready is high only while the sequencer is idle,
// which it reaches at the edge that loads the response, once the output
// register is free; a finished response waits in the output register while
// the next request is taken.
// Table contents are not cleared at reset, only the fill count.
module node_table_oldest_evict #(
   parameter int NODE_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // node_addr[15:0], link_rssi[23:16], link_snr[31:24], hop_count[39:32],
   // now_time_ms[71:40], event_code_in[79:72], event_severity_in[87:80],
   // event_epoch_in[119:88], read_index[123:120], zero fill [127:124]
   input  logic [127:0]                      req_tdata,
   // operation[1:0]
   input  logic [1:0]                        req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // slot_used[3:0], entry_addr[19:4], entry_last_ms[51:20], entry_rssi[59:52],
   // entry_snr[67:60], entry_hops[75:68], entry_frames[107:76],
   // entry_event_code[115:108], entry_event_severity[123:116],
   // entry_event_epoch[155:124], fill_count[160:156], zero fill [167:161]
   output logic [167:0]                      rsp_tdata,
   // done_ok[0]
   output logic [0:0]                        rsp_tuser,
   // CSR port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                              csr_pready
);

   localparam int IDX_W = $clog2(NODE_SLOTS);
   localparam int CNT_W = $clog2(NODE_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_TAIL,
      S_DECIDE,
      S_FETCH,
      S_FETCH_WAIT,
      S_UPDATE,
      S_RESPOND
   } state_type;

   // ---------------- CSR registers ----------------
   logic [nt_pkg::ADDR_W-1:0] unassigned_ff, unassigned_in;
   logic [nt_pkg::ADDR_W-1:0] broadcast_ff, broadcast_in;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unassigned_in = unassigned_ff;
      broadcast_in  = broadcast_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            nt_pkg::REG_UNASSIGNED: unassigned_in = csr_pwdata[nt_pkg::ADDR_W-1:0];
            nt_pkg::REG_BROADCAST:  broadcast_in  = csr_pwdata[nt_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         nt_pkg::REG_UNASSIGNED: csr_prdata = {16'd0, unassigned_ff};
         nt_pkg::REG_BROADCAST:  csr_prdata = {16'd0, broadcast_ff};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unassigned_ff <= 16'h0000;
         broadcast_ff  <= 16'hFFFF;
      end else begin
         unassigned_ff <= unassigned_in;
         broadcast_ff  <= broadcast_in;
      end
   end

   // ---------------- request fields ----------------
   logic [nt_pkg::ADDR_W-1:0]  req_addr;
   logic [nt_pkg::INDEX_W-1:0] req_index;
   logic [1:0]                 req_op;

   assign req_addr  = req_tdata[15:0];
   assign req_index = req_tdata[123:120];
   assign req_op    = req_tuser;

   // latched request
   logic [123:0] item_ff, item_in;
   logic [1:0]   op_ff, op_in;

   logic [nt_pkg::ADDR_W-1:0]  key_addr;
   logic [nt_pkg::INDEX_W-1:0] item_index;
   assign key_addr   = item_ff[15:0];
   assign item_index = item_ff[123:120];

   // ---------------- sequencer state ----------------
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   samp_v_ff, samp_v_in;
   logic [IDX_W-1:0]       samp_idx_ff, samp_idx_in;
   logic [IDX_W-1:0]       pick_ff, pick_in;
   logic                   ok_ff, ok_in;
   nt_pkg::entry_type      cur_ff, cur_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_ok_ff, out_ok_in;
   logic [3:0]             out_slot_ff, out_slot_in;
   logic [4:0]             out_fill_ff, out_fill_in;
   nt_pkg::entry_type      out_entry_ff, out_entry_in;

   // table and scan unit
   logic [IDX_W-1:0]       rd_addr;
   nt_pkg::entry_type      rd_data;
   logic                   wr_en;
   nt_pkg::entry_type      upd_entry;
   nt_pkg::scan_ctl_type   scan_ctl;
   logic                   scan_found;
   logic [IDX_W-1:0]       scan_match;
   logic [IDX_W-1:0]       scan_oldest;

   // width helpers
   logic [IDX_W+3:0]       req_index_wide;
   logic [IDX_W+3:0]       pick_wide;
   logic [CNT_W+4:0]       count_wide;
   logic                   req_in_range;
   logic                   req_reserved;
   logic                   accept;
   logic                   out_free;

   assign req_index_wide = {{IDX_W{1'b0}}, req_index};
   assign pick_wide      = {4'd0, pick_ff};
   assign count_wide     = {5'd0, count_ff};
   assign req_in_range   = {{CNT_W{1'b0}}, req_index} < {4'd0, count_ff};
   assign req_reserved   = (req_addr == unassigned_ff) || (req_addr == broadcast_ff);
   assign accept         = req_tvalid && req_tready;
   assign out_free       = !rsp_valid_ff || rsp_tready;
   assign req_tready     = (state_ff == S_IDLE);

   // new slot contents for heard and event requests
   always_comb begin
      upd_entry = cur_ff;
      if (op_ff == nt_pkg::OP_HEARD) begin
         upd_entry.last_ms = item_ff[71:40];
         upd_entry.rssi    = item_ff[23:16];
         upd_entry.snr     = item_ff[31:24];
         upd_entry.hops    = item_ff[39:32];
         upd_entry.frames  = cur_ff.frames + 32'd1;
      end else begin
         upd_entry.evt_code       = item_ff[79:72];
         upd_entry.event_severity = item_ff[87:80];
         upd_entry.event_epoch    = item_ff[119:88];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      samp_v_in    = 1'b0;
      samp_idx_in  = scan_idx_ff;
      pick_in      = pick_ff;
      ok_in        = ok_ff;
      cur_in       = cur_ff;
      item_in      = item_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_ok_in    = out_ok_ff;
      out_slot_in  = out_slot_ff;
      out_fill_in  = out_fill_ff;
      out_entry_in = out_entry_ff;
      rd_addr      = pick_ff;
      wr_en        = 1'b0;
      scan_ctl     = '0;
      scan_ctl.sample   = samp_v_ff;
      scan_ctl.in_range = CNT_W'(samp_idx_ff) < count_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_tdata[123:0];
               op_in   = req_op;
               ok_in   = 1'b0;
               if ((req_op == nt_pkg::OP_HEARD && !req_reserved) ||
                   req_op == nt_pkg::OP_EVENT) begin
                  scan_ctl.start = 1'b1;
                  scan_idx_in    = '0;
                  state_in       = S_SCAN;
               end else if (req_op == nt_pkg::OP_READ && req_in_range) begin
                  pick_in  = req_index_wide[IDX_W-1:0];
                  ok_in    = 1'b1;
                  state_in = S_FETCH;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_SCAN: begin
            rd_addr     = scan_idx_ff;
            samp_v_in   = 1'b1;
            samp_idx_in = scan_idx_ff;
            if (scan_idx_ff == IDX_W'(NODE_SLOTS - 1)) begin
               state_in = S_SCAN_TAIL;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_SCAN_TAIL: begin
            // last sample enters the compare unit here
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            ok_in = 1'b1;
            if (scan_found) begin
               pick_in  = scan_match;
               state_in = S_FETCH;
            end else begin
               // allocate: next free slot or evict the oldest, cleared
               cur_in      = '0;
               cur_in.addr = key_addr;
               if (count_ff < CNT_W'(NODE_SLOTS)) begin
                  pick_in  = count_ff[IDX_W-1:0];
                  count_in = count_ff + 1'b1;
               end else begin
                  pick_in = scan_oldest;
               end
               state_in = S_UPDATE;
            end
         end
         S_FETCH: begin
            rd_addr  = pick_ff;
            state_in = S_FETCH_WAIT;
         end
         S_FETCH_WAIT: begin
            cur_in   = rd_data;
            state_in = (op_ff == nt_pkg::OP_READ) ? S_RESPOND : S_UPDATE;
         end
         S_UPDATE: begin
            wr_en    = 1'b1;
            cur_in   = upd_entry;
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_ok_in    = ok_ff;
               out_entry_in = ok_ff ? cur_ff : '0;
               out_fill_in  = count_wide[4:0];
               if (ok_ff) begin
                  out_slot_in = pick_wide[3:0];
               end else if (op_ff == nt_pkg::OP_READ) begin
                  out_slot_in = item_index;
               end else begin
                  out_slot_in = 4'd0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         samp_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         samp_v_ff    <= samp_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff  <= scan_idx_in;
      samp_idx_ff  <= samp_idx_in;
      pick_ff      <= pick_in;
      ok_ff        <= ok_in;
      cur_ff       <= cur_in;
      item_ff      <= item_in;
      op_ff        <= op_in;
      out_ok_ff    <= out_ok_in;
      out_slot_ff  <= out_slot_in;
      out_fill_ff  <= out_fill_in;
      out_entry_ff <= out_entry_in;
   end

   nt_table #(
      .DEPTH (NODE_SLOTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (pick_ff),
      .wr_data (upd_entry)
   );

   nt_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .ctl            (scan_ctl),
      .sample_idx     (samp_idx_ff),
      .sample_addr    (rd_data.addr),
      .sample_last_ms (rd_data.last_ms),
      .key_addr       (key_addr),
      .found          (scan_found),
      .match_idx      (scan_match),
      .oldest_idx     (scan_oldest)
   );

   // ---------------- response port ----------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tdata  = {7'd0,
                        out_fill_ff,
                        out_entry_ff.event_epoch,
                        out_entry_ff.event_severity,
                        out_entry_ff.evt_code,
                        out_entry_ff.frames,
                        out_entry_ff.hops,
                        out_entry_ff.snr,
                        out_entry_ff.rssi,
                        out_entry_ff.last_ms,
                        out_entry_ff.addr,
                        out_slot_ff};

endmodule

@@ sim/node_table_monitor.sv @@
// Watches the node table channels, predicts every response and compares it.
`timescale 1ns / 1ps

module node_table_monitor
   import nt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // node_addr, link_rssi, link_snr, hop_count, now_time_ms, event_code_in,
   // event_severity_in, event_epoch_in, read_index, zero fill
   input  logic [127:0] req_tdata,
   // operation
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // slot_used, entry_addr, entry_last_ms, entry_rssi, entry_snr, entry_hops,
   // entry_frames, entry_event_code, entry_event_severity, entry_event_epoch,
   // fill_count, zero fill
   input  logic [167:0] rsp_tdata,
   // done_ok
   input  logic [0:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic         csr_pready,
   output int           mismatch_count,
   output int           replies_due,
   output int           replies_seen,
   output int           evictions_seen
);

   localparam int SLOTS = 16;

   typedef struct {
      logic            ok;
      logic [3:0]      slot;
      entry_type       entry;
      logic [FILL_W-1:0] fill;
   } reply_type;

   entry_type         node_store [SLOTS];
   int unsigned       slots_taken;
   logic [ADDR_W-1:0] unassigned_addr;
   logic [ADDR_W-1:0] broadcast_addr;
   reply_type         reply_q [$];
   int                errors;
   int                evictions;
   int                replies;

   // Find the node, else take the next free slot, else evict the stalest one.
   function automatic int take_slot(logic [ADDR_W-1:0] addr);
      int pick;
      for (int i = 0; i < slots_taken; i++) begin
         if (node_store[i].addr == addr) return i;
      end
      if (slots_taken < SLOTS) begin
         pick = slots_taken;
         slots_taken++;
      end else begin
         pick = 0;
         for (int i = 1; i < SLOTS; i++) begin
            if (node_store[i].last_ms < node_store[pick].last_ms) pick = i;
         end
         evictions++;
      end
      node_store[pick] = '0;
      node_store[pick].addr = addr;
      return pick;
   endfunction

   function automatic reply_type apply_request(op_type kind, logic [127:0] d);
      reply_type         r;
      int                s;
      logic [ADDR_W-1:0] addr;
      logic [INDEX_W-1:0] idx;
      r.ok = 1'b0;
      r.slot = '0;
      r.entry = '0;
      addr = d[15:0];
      idx = d[123:120];
      case (kind)
         OP_HEARD: begin
            if (addr != unassigned_addr && addr != broadcast_addr) begin
               s = take_slot(addr);
               node_store[s].last_ms = d[71:40];
               node_store[s].rssi = d[23:16];
               node_store[s].snr = d[31:24];
               node_store[s].hops = d[39:32];
               node_store[s].frames = node_store[s].frames + 1;
               r.ok = 1'b1;
               r.slot = s[3:0];
               r.entry = node_store[s];
            end
         end
         OP_EVENT: begin
            // events bypass the address filter
            s = take_slot(addr);
            node_store[s].evt_code = d[79:72];
            node_store[s].event_severity = d[87:80];
            node_store[s].event_epoch = d[119:88];
            r.ok = 1'b1;
            r.slot = s[3:0];
            r.entry = node_store[s];
         end
         OP_READ: begin
            r.slot = idx;
            if (idx < slots_taken) begin
               r.ok = 1'b1;
               r.entry = node_store[idx];
            end
         end
         default: ;
      endcase
      r.fill = slots_taken[FILL_W-1:0];
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: response %0d, %s expected 0x%0h, got 0x%0h",
                     $time, replies, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : watch
      reply_type want;
      reply_type got;
      if (reset) begin
         reply_q.delete();
         slots_taken = 0;
         unassigned_addr = '0;
         broadcast_addr = '1;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_UNASSIGNED) unassigned_addr = csr_pwdata[15:0];
               else broadcast_addr = csr_pwdata[15:0];
            end else begin
               compare_field("register readback",
                             (csr_paddr[2] == REG_UNASSIGNED) ? unassigned_addr
                                                              : broadcast_addr,
                             csr_prdata[15:0]);
            end
         end
         // retire the response before taking a new request
         if (rsp_tvalid && rsp_tready) begin
            replies++;
            got.ok = rsp_tuser[0];
            got.slot = rsp_tdata[3:0];
            got.entry.addr = rsp_tdata[19:4];
            got.entry.last_ms = rsp_tdata[51:20];
            got.entry.rssi = rsp_tdata[59:52];
            got.entry.snr = rsp_tdata[67:60];
            got.entry.hops = rsp_tdata[75:68];
            got.entry.frames = rsp_tdata[107:76];
            got.entry.evt_code = rsp_tdata[115:108];
            got.entry.event_severity = rsp_tdata[123:116];
            got.entry.event_epoch = rsp_tdata[155:124];
            got.fill = rsp_tdata[160:156];
            if (reply_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%0t: response %0d arrived with no request open",
                                          $time, replies);
            end else begin
               want = reply_q.pop_front();
               compare_field("done_ok", want.ok, got.ok);
               compare_field("slot_used", want.slot, got.slot);
               compare_field("entry_addr", want.entry.addr, got.entry.addr);
               compare_field("entry_last_ms", want.entry.last_ms, got.entry.last_ms);
               compare_field("entry_rssi", want.entry.rssi, got.entry.rssi);
               compare_field("entry_snr", want.entry.snr, got.entry.snr);
               compare_field("entry_hops", want.entry.hops, got.entry.hops);
               compare_field("entry_frames", want.entry.frames, got.entry.frames);
               compare_field("entry_event_code", want.entry.evt_code,
                             got.entry.evt_code);
               compare_field("entry_event_severity", want.entry.event_severity,
                             got.entry.event_severity);
               compare_field("entry_event_epoch", want.entry.event_epoch,
                             got.entry.event_epoch);
               compare_field("fill_count", want.fill, got.fill);
            end
         end
         if (req_tvalid && req_tready) begin
            reply_q.push_back(apply_request(op_type'(req_tuser), req_tdata));
         end
      end
      mismatch_count <= errors;
      replies_due <= reply_q.size();
      replies_seen <= replies;
      evictions_seen <= evictions;
   end

endmodule

@@ sim/testbench.sv @@
// Top of the node table testbench: clock, reset, request and CSR stimulus, verdict.
`timescale 1ns / 1ps

module testbench;
   import nt_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // node_addr[15:0], link_rssi[23:16], link_snr[31:24], hop_count[39:32],
   // now_time_ms[71:40], event_code_in[79:72], event_severity_in[87:80],
   // event_epoch_in[119:88], read_index[123:120], zero fill [127:124]
   logic [127:0] req_tdata;
   // operation[1:0]
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // slot_used[3:0], entry_addr[19:4], entry_last_ms[51:20], entry_rssi[59:52],
   // entry_snr[67:60], entry_hops[75:68], entry_frames[107:76],
   // entry_event_code[115:108], entry_event_severity[123:116],
   // entry_event_epoch[155:124], fill_count[160:156], zero fill [167:161]
   logic [167:0] rsp_tdata;
   // done_ok[0]
   logic [0:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic         csr_pready;

   int           fail_count;
   int           replies_due;
   int           replies_seen;
   int           evictions_seen;
   int           sent_by_kind [4];
   int           burst_left;
   int           settings_tried;
   logic [15:0]  filt_unassigned;
   logic [15:0]  filt_broadcast;
   logic [15:0]  addr_pool [$];
   logic [31:0]  heard_clock;

   node_table_oldest_evict #(.NODE_SLOTS(16)) dut (.*);

   node_table_monitor table_watch (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready,
      .mismatch_count(fail_count),
      .replies_due,
      .replies_seen,
      .evictions_seen
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("node_table_oldest_evict regression: fail");
      $finish;
   end

   function automatic logic [127:0] random_fill();
      logic [127:0] d;
      d = {$urandom, $urandom, $urandom, $urandom};
      d[127:124] = '0;
      return d;
   endfunction

   function automatic logic [15:0] pick_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      if (r < 95) return r[0] ? filt_unassigned : filt_broadcast;
      return 16'($urandom);
   endfunction

   // Mostly a slowly rising clock, so the stalest node is well defined, plus ties.
   function automatic logic [31:0] pick_time();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         heard_clock += $urandom_range(0, 3);
         return heard_clock;
      end
      if (r < 85) return $urandom;
      return $urandom_range(0, 3);
   endfunction

   task automatic send_request(op_type kind, logic [127:0] data);
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      sent_by_kind[kind]++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 24);
      end
   endtask

   task automatic report_heard(logic [15:0] addr, logic [7:0] rssi, logic [7:0] snr,
                               logic [7:0] hops, logic [31:0] now);
      logic [127:0] d;
      d = random_fill();
      d[15:0] = addr;
      d[23:16] = rssi;
      d[31:24] = snr;
      d[39:32] = hops;
      d[71:40] = now;
      send_request(OP_HEARD, d);
   endtask

   task automatic report_event(logic [15:0] addr, logic [7:0] code, logic [7:0] sev,
                               logic [31:0] epoch);
      logic [127:0] d;
      d = random_fill();
      d[15:0] = addr;
      d[79:72] = code;
      d[87:80] = sev;
      d[119:88] = epoch;
      send_request(OP_EVENT, d);
   endtask

   task automatic read_slot(logic [3:0] idx);
      logic [127:0] d;
      d = random_fill();
      d[123:120] = idx;
      send_request(OP_READ, d);
   endtask

   task automatic random_request();
      logic [127:0] d;
      int pick;
      d = random_fill();
      d[15:0] = pick_address();
      d[71:40] = pick_time();
      pick = $urandom_range(0, 99);
      if (pick < 45) send_request(OP_HEARD, d);
      else if (pick < 70) send_request(OP_EVENT, d);
      else if (pick < 95) send_request(OP_READ, d);
      else send_request(OP_NONE, d);
   endtask

   // Hold the request side until every open request has its response.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (replies_due != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic idx, logic [15:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_filters(logic [15:0] unassigned, logic [15:0] broadcast);
      drain();
      csr_access(1'b1, REG_UNASSIGNED, unassigned);
      csr_access(1'b1, REG_BROADCAST, broadcast);
      csr_access(1'b0, REG_UNASSIGNED, 16'h0000);
      csr_access(1'b0, REG_BROADCAST, 16'h0000);
      filt_unassigned = unassigned;
      filt_broadcast = broadcast;
      settings_tried++;
   endtask

   // Response side: stall patterns in segments, with two long hold-offs.
   initial begin : receiver
      int mode;
      int span;
      int holds_done;
      int hold_cycles;
      holds_done = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < 2 && replies_seen >= 300 + 800 * holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < 400) begin
               @(posedge clock);
               hold_cycles++;
            end
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            for (int i = 0; i < span; i++) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= $urandom_range(0, 1);
                  2:       rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ($urandom_range(0, 3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int n;
      logic [15:0] shared;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_NONE;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      burst_left = 8;
      settings_tried = 0;
      heard_clock = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, reserved addresses, field extremes, fill edge
      set_filters(16'h0000, 16'hFFFF);
      read_slot(4'd0);
      read_slot(4'd15);
      send_request(OP_NONE, random_fill());
      report_heard(16'h0000, 8'h11, 8'h22, 8'h33, 32'h10);
      report_heard(16'hFFFF, 8'h11, 8'h22, 8'h33, 32'h10);
      report_event(16'hFFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF);
      report_event(16'h0000, 8'h00, 8'hFF, 32'h0000_0000);
      // a broadcast node already in the table is still filtered for heard frames
      report_heard(16'hFFFF, 8'h44, 8'h55, 8'h66, 32'h20);
      report_heard(16'h1234, 8'h80, 8'h00, 8'hFF, 32'hFFFF_FFFF);
      report_heard(16'h1234, 8'h7F, 8'hFF, 8'h00, 32'h0000_0000);
      report_event(16'h1234, 8'h5A, 8'hA5, 32'h1234_5678);
      report_heard(16'h8001, 8'hC3, 8'h3C, 8'h01, 32'h8000_0000);
      for (int i = 0; i < 5; i++) read_slot(i[3:0]);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_filters(16'hFFFF, 16'h0000);
            1: set_filters(16'($urandom), 16'($urandom));
            2: begin
               shared = 16'($urandom);
               set_filters(shared, shared);
            end
            3: set_filters(16'h0001, 16'hFFFE);
            4: set_filters(16'($urandom), 16'($urandom));
            default: set_filters(16'h0000, 16'hFFFF);
         endcase
         // more addresses than slots forces eviction, fewer gives mostly hits
         addr_pool.delete();
         n = $urandom_range(10, 28);
         repeat (n) addr_pool.push_back(16'($urandom));
         repeat (270) random_request();
      end

      drain();
      $display("Sent %0d heard, %0d event, %0d read, %0d bad-code requests, %0d filter sets",
               sent_by_kind[OP_HEARD], sent_by_kind[OP_EVENT], sent_by_kind[OP_READ],
               sent_by_kind[OP_NONE], settings_tried);
      $display("Checked %0d responses, %0d of which followed an eviction of the stalest node",
               replies_seen, evictions_seen);
      if (fail_count == 0) begin
         $display("node_table_oldest_evict regression: pass");
      end else begin
         $display("node_table_oldest_evict regression: fail");
      end
      $finish;
   end

endmodule
